/* rtl/source_token_lexer_defines.svh */
// Assertion macros used by the lexer's checker file.
`ifndef SOURCE_TOKEN_LEXER_DEFINES_SVH
`define SOURCE_TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is held.
`define STL_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, off while reset is held.
`define STL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed: next-cycle implication");

`endif

/* rtl/stl_pkg.sv */
// Shared types, constants and character tables of the source token lexer.
package stl_pkg;

    // Token kinds with a fixed meaning.
    localparam logic [5:0] K_ID  = 6'd0;
    localparam logic [5:0] K_NUM = 6'd1;
    localparam logic [5:0] K_END = 6'd46;
    localparam logic [5:0] K_ERR = 6'd47;

    // Characters that steer the lexer.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;

    // Result queue geometry.
    localparam int QDEPTH   = 4;
    localparam int Q_PTR_W  = $clog2(QDEPTH);
    localparam int Q_CNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start_pos;
        logic [15:0] length;
        logic [19:0] line_no;
        logic [15:0] column_no;
        logic [31:0] token_index;
        logic        last;
    } t_token;

    // Operator row: kinds for the lead alone, followed by '=', doubled,
    // and doubled then followed by '='.
    typedef struct packed {
        logic       is_lead;
        logic [5:0] alone;
        logic [5:0] with_eq;
        logic       has_alt;
        logic [5:0] with_alt;
        logic       has_triple;
        logic [5:0] triple;
    } t_op_info;

    function automatic t_op_info op_info(input logic [7:0] c);
        t_op_info info;
        info = '0;
        unique case (c)
            8'h3D: begin info.is_lead = 1'b1; info.alone = 6'd15; info.with_eq = 6'd14; end
            8'h2A: begin info.is_lead = 1'b1; info.alone = 6'd17; info.with_eq = 6'd16; end
            8'h2F: begin info.is_lead = 1'b1; info.alone = 6'd19; info.with_eq = 6'd18; end
            8'h25: begin info.is_lead = 1'b1; info.alone = 6'd21; info.with_eq = 6'd20; end
            8'h21: begin info.is_lead = 1'b1; info.alone = 6'd23; info.with_eq = 6'd22; end
            8'h5E: begin info.is_lead = 1'b1; info.alone = 6'd25; info.with_eq = 6'd24; end
            8'h26: begin
                info.is_lead = 1'b1; info.alone = 6'd28; info.with_eq = 6'd27;
                info.has_alt = 1'b1; info.with_alt = 6'd26;
            end
            8'h7C: begin
                info.is_lead = 1'b1; info.alone = 6'd31; info.with_eq = 6'd30;
                info.has_alt = 1'b1; info.with_alt = 6'd29;
            end
            8'h2D: begin
                info.is_lead = 1'b1; info.alone = 6'd34; info.with_eq = 6'd32;
                info.has_alt = 1'b1; info.with_alt = 6'd33;
            end
            8'h2B: begin
                info.is_lead = 1'b1; info.alone = 6'd37; info.with_eq = 6'd35;
                info.has_alt = 1'b1; info.with_alt = 6'd36;
            end
            8'h3C: begin
                info.is_lead = 1'b1; info.alone = 6'd41; info.with_eq = 6'd38;
                info.has_alt = 1'b1; info.with_alt = 6'd40;
                info.has_triple = 1'b1; info.triple = 6'd39;
            end
            8'h3E: begin
                info.is_lead = 1'b1; info.alone = 6'd45; info.with_eq = 6'd42;
                info.has_alt = 1'b1; info.with_alt = 6'd44;
                info.has_triple = 1'b1; info.triple = 6'd43;
            end
            default: info = '0;
        endcase
        return info;
    endfunction

    // Kind of a one-character punctuation token; zero when the byte is none.
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            8'h28:   k = 6'd2;
            8'h29:   k = 6'd3;
            8'h7B:   k = 6'd4;
            8'h7D:   k = 6'd5;
            8'h5B:   k = 6'd6;
            8'h5D:   k = 6'd7;
            8'h2C:   k = 6'd8;
            8'h2E:   k = 6'd9;
            8'h3A:   k = 6'd10;
            8'h3B:   k = 6'd11;
            8'h3F:   k = 6'd12;
            8'h5F:   k = 6'd13;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_word_end(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) ||
               (c == CH_LPAREN) || (c == CH_SEMI) || (c == CH_COLON) || (c == CH_LBRACE);
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic t_token make_token(input logic [5:0] kind, input logic [31:0] start,
                                          input logic [15:0] len, input logic [19:0] line,
                                          input logic [15:0] col, input logic [31:0] idx);
        t_token t;
        t.kind        = kind;
        t.start_pos   = start;
        t.length      = len;
        t.line_no     = line;
        t.column_no   = col;
        t.token_index = idx;
        t.last        = 1'b0;
        return t;
    endfunction

endpackage

/* rtl/stl_out_queue.sv */
// Small result queue that takes up to two tokens a cycle and hands out one.
module stl_out_queue import stl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_n,
    input  t_token             i_push0,
    input  t_token             i_push1,
    input  logic               i_pop,
    output t_token             o_head,
    output logic [Q_CNT_W-1:0] o_count
);

    t_token               r_mem [QDEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   wr_ptr_inc;

    assign wr_ptr_inc = r_wr_ptr + Q_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_ptr_inc] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_PTR_W'(i_push_n);
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push_n) - Q_CNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* rtl/source_token_lexer.sv */
// Top level of the byte-serial source token lexer.
// The lexer takes one source byte per transfer, a byte of zero ending the
// input, and sends one token record per output transfer. It accepts a byte
// in every cycle unless it stalls: a byte is held in the input register, is
// lexed in a single pass against the lexer state, and its tokens land in a
// four-entry result queue that feeds the output. A byte can finish a
// pending operator or word and start a new token at once, giving two
// tokens; the queue drains one token a cycle while the output side does not
// stall, and the input stalls only while the queue holds more than two
// tokens, which happens when the output side stalls or when bytes keep
// producing two tokens each. Operators are matched longest first with a
// lookahead of one byte, space, tab and newline separate tokens, "//"
// comments run to the newline, and quoted strings give identifier tokens
// for their contents. After the end token or an error token, every byte is
// taken and dropped until reset.
module source_token_lexer import stl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_kind,
    output logic [31:0] o_start_pos,
    output logic [15:0] o_length,
    output logic [19:0] o_line_no,
    output logic [15:0] o_column_no,
    output logic [31:0] o_token_index,
    output logic        o_last
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_OP1,
        M_OP2,
        M_COMMENT,
        M_STRING,
        M_WORD,
        M_DONE,
        M_ERROR
    } t_lex_mode;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_ch;

    // Lexer state.
    t_lex_mode   r_mode,      n_mode;
    logic [7:0]  r_first,     n_first;
    logic        r_qsingle,   n_qsingle;
    logic        r_wnum,      n_wnum;
    logic [31:0] r_tok_start, n_tok_start;
    logic [15:0] r_tok_len,   n_tok_len;
    logic [19:0] r_tok_line,  n_tok_line;
    logic [15:0] r_tok_col,   n_tok_col;
    logic [31:0] r_pos,       n_pos;
    logic [19:0] r_line,      n_line;
    logic [15:0] r_col,       n_col;
    logic [31:0] r_tcnt,      n_tcnt;

    t_token             res0;
    t_token             res1;
    logic [1:0]         res_n;
    logic [1:0]         push_n;
    logic               do_fresh;
    logic               consume;
    logic               pop;
    t_op_info           op;
    t_op_info           op_ch;
    t_token             head;
    logic [Q_CNT_W-1:0] q_count;
    logic [5:0]         sk;

    // The byte in the input register is lexed once the queue has room for
    // the two tokens it may produce.
    assign consume = r_in_valid && (q_count <= Q_CNT_W'(QDEPTH - 2));
    assign o_stall = r_in_valid && !consume;
    assign o_valid = (q_count != '0);
    assign pop     = o_valid && !i_stall;
    assign push_n  = consume ? res_n : 2'd0;

    assign op    = op_info(r_first);
    assign op_ch = op_info(r_ch);
    assign sk    = single_kind(r_ch);

    always_comb begin
        n_mode      = r_mode;
        n_first     = r_first;
        n_qsingle   = r_qsingle;
        n_wnum      = r_wnum;
        n_tok_start = r_tok_start;
        n_tok_len   = r_tok_len;
        n_tok_line  = r_tok_line;
        n_tok_col   = r_tok_col;
        n_pos       = r_pos;
        n_line      = r_line;
        n_col       = r_col;
        n_tcnt      = r_tcnt;
        res0        = '0;
        res1        = '0;
        res_n       = 2'd0;
        do_fresh    = 1'b0;

        // First part: the byte against the token in progress. This part
        // gives at most one token and may hand the byte on to be lexed
        // afresh.
        unique case (r_mode)
            M_IDLE: begin
                do_fresh = 1'b1;
            end
            M_OP1: begin
                if ((r_first == CH_SLASH) && (r_ch == CH_SLASH)) begin
                    n_mode = M_COMMENT;
                end else if (r_ch == CH_EQ) begin
                    res0   = make_token(op.with_eq, r_tok_start, 16'd2, r_tok_line,
                                        r_tok_col, r_tcnt);
                    res_n  = 2'd1;
                    n_tcnt = r_tcnt + 32'd1;
                    n_mode = M_IDLE;
                end else if (op.has_alt && (r_ch == r_first)) begin
                    if (op.has_triple) begin
                        n_mode = M_OP2;
                    end else begin
                        res0   = make_token(op.with_alt, r_tok_start, 16'd2, r_tok_line,
                                            r_tok_col, r_tcnt);
                        res_n  = 2'd1;
                        n_tcnt = r_tcnt + 32'd1;
                        n_mode = M_IDLE;
                    end
                end else begin
                    res0     = make_token(op.alone, r_tok_start, 16'd1, r_tok_line,
                                          r_tok_col, r_tcnt);
                    res_n    = 2'd1;
                    n_tcnt   = r_tcnt + 32'd1;
                    n_mode   = M_IDLE;
                    do_fresh = 1'b1;
                end
            end
            M_OP2: begin
                // Only the shift leads reach here, already doubled.
                if (r_ch == CH_EQ) begin
                    res0 = make_token(op.triple, r_tok_start, 16'd3, r_tok_line,
                                      r_tok_col, r_tcnt);
                end else begin
                    res0     = make_token(op.with_alt, r_tok_start, 16'd2, r_tok_line,
                                          r_tok_col, r_tcnt);
                    do_fresh = 1'b1;
                end
                res_n  = 2'd1;
                n_tcnt = r_tcnt + 32'd1;
                n_mode = M_IDLE;
            end
            M_COMMENT: begin
                if (r_ch == CH_LF) begin
                    n_mode = M_IDLE;
                end else if (r_ch == CH_NUL) begin
                    do_fresh = 1'b1;
                end
            end
            M_STRING: begin
                if (r_ch == (r_qsingle ? CH_SQUOTE : CH_DQUOTE)) begin
                    res0   = make_token(K_ID, r_tok_start, r_tok_len, r_tok_line,
                                        r_tok_col, r_tcnt);
                    res_n  = 2'd1;
                    n_tcnt = r_tcnt + 32'd1;
                    n_mode = M_IDLE;
                end else if (r_ch == CH_NUL) begin
                    // Unterminated string: report it where it began.
                    res0   = make_token(K_ERR, r_tok_start, r_tok_len, r_tok_line,
                                        r_tok_col, r_tcnt);
                    res_n  = 2'd1;
                    n_mode = M_ERROR;
                end else begin
                    n_tok_len = sat_inc16(r_tok_len);
                end
            end
            M_WORD: begin
                if (is_word_end(r_ch)) begin
                    res0     = make_token(r_wnum ? K_NUM : K_ID, r_tok_start, r_tok_len,
                                          r_tok_line, r_tok_col, r_tcnt);
                    res_n    = 2'd1;
                    n_tcnt   = r_tcnt + 32'd1;
                    n_mode   = M_IDLE;
                    do_fresh = 1'b1;
                end else begin
                    n_tok_len = sat_inc16(r_tok_len);
                end
            end
            M_DONE, M_ERROR: begin
                // Input is dropped until reset.
            end
        endcase

        // Second part: the byte as the start of something new.
        if (do_fresh) begin
            if (r_ch == CH_NUL) begin
                if (res_n == 2'd0) begin
                    res0 = make_token(K_END, r_pos, 16'd0, r_line, r_col, n_tcnt);
                end else begin
                    res1 = make_token(K_END, r_pos, 16'd0, r_line, r_col, n_tcnt);
                end
                res_n  = res_n + 2'd1;
                n_mode = M_DONE;
            end else if ((r_ch == CH_SPACE) || (r_ch == CH_TAB) || (r_ch == CH_LF)) begin
                n_mode = M_IDLE;
            end else if ((r_ch == CH_DQUOTE) || (r_ch == CH_SQUOTE)) begin
                // The token starts at the first byte inside the quotes.
                n_qsingle   = (r_ch == CH_SQUOTE);
                n_tok_start = r_pos + 32'd1;
                n_tok_line  = r_line;
                n_tok_col   = sat_inc16(r_col);
                n_tok_len   = 16'd0;
                n_mode      = M_STRING;
            end else if (is_alnum(r_ch)) begin
                n_wnum      = is_digit(r_ch);
                n_tok_start = r_pos;
                n_tok_line  = r_line;
                n_tok_col   = r_col;
                n_tok_len   = 16'd1;
                n_mode      = M_WORD;
            end else if (sk != 6'd0) begin
                if (res_n == 2'd0) begin
                    res0 = make_token(sk, r_pos, 16'd1, r_line, r_col, n_tcnt);
                end else begin
                    res1 = make_token(sk, r_pos, 16'd1, r_line, r_col, n_tcnt);
                end
                res_n  = res_n + 2'd1;
                n_tcnt = n_tcnt + 32'd1;
                n_mode = M_IDLE;
            end else if (op_ch.is_lead) begin
                n_first     = r_ch;
                n_tok_start = r_pos;
                n_tok_line  = r_line;
                n_tok_col   = r_col;
                n_tok_len   = 16'd1;
                n_mode      = M_OP1;
            end else begin
                if (res_n == 2'd0) begin
                    res0 = make_token(K_ERR, r_pos, 16'd1, r_line, r_col, n_tcnt);
                end else begin
                    res1 = make_token(K_ERR, r_pos, 16'd1, r_line, r_col, n_tcnt);
                end
                res_n  = res_n + 2'd1;
                n_mode = M_ERROR;
            end
        end

        // Flag the final token caused by this byte.
        if (res_n == 2'd1) begin
            res0.last = 1'b1;
        end else if (res_n == 2'd2) begin
            res1.last = 1'b1;
        end

        // Position, line and column move with every byte that is lexed.
        if ((r_mode != M_DONE) && (r_mode != M_ERROR)) begin
            if (r_ch == CH_LF) begin
                n_line = r_line + 20'd1;
                n_col  = 16'd0;
            end else begin
                n_col = sat_inc16(r_col);
            end
            n_pos = r_pos + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_ch        <= '0;
            r_mode      <= M_IDLE;
            r_first     <= '0;
            r_qsingle   <= 1'b0;
            r_wnum      <= 1'b0;
            r_tok_start <= '0;
            r_tok_len   <= '0;
            r_tok_line  <= '0;
            r_tok_col   <= '0;
            r_pos       <= '0;
            r_line      <= '0;
            r_col       <= '0;
            r_tcnt      <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
                r_ch       <= i_ch;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_mode      <= n_mode;
                r_first     <= n_first;
                r_qsingle   <= n_qsingle;
                r_wnum      <= n_wnum;
                r_tok_start <= n_tok_start;
                r_tok_len   <= n_tok_len;
                r_tok_line  <= n_tok_line;
                r_tok_col   <= n_tok_col;
                r_pos       <= n_pos;
                r_line      <= n_line;
                r_col       <= n_col;
                r_tcnt      <= n_tcnt;
            end
        end
    end

    stl_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_push0  (res0),
        .i_push1  (res1),
        .i_pop    (pop),
        .o_head   (head),
        .o_count  (q_count)
    );

    assign o_kind        = head.kind;
    assign o_start_pos   = head.start_pos;
    assign o_length      = head.length;
    assign o_line_no     = head.line_no;
    assign o_column_no   = head.column_no;
    assign o_token_index = head.token_index;
    assign o_last        = head.last;

endmodule

/* rtl/stl_checker.sv */
// Port-level checks of the source token lexer and their binding.
`include "source_token_lexer_defines.svh"

module stl_checker import stl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [5:0]  o_kind,
    input logic [31:0] o_start_pos,
    input logic [15:0] o_length,
    input logic [31:0] o_token_index,
    input logic        o_last
);

    `STL_ASSERT_NEXT(a_stalled_token_holds, o_valid && i_stall, o_valid && $stable(o_kind) && $stable(o_start_pos) && $stable(o_token_index))

    `STL_ASSERT_NEXT(a_quiet_after_final, o_valid && !i_stall && (o_kind == K_END || o_kind == K_ERR), !o_valid)

    `STL_ASSERT_IMPLIES(a_end_token_shape, o_valid && o_kind == K_END, o_length == 16'd0 && o_last)

    `STL_ASSERT_IMPLIES(a_kind_in_range, o_valid, o_kind <= K_ERR)

endmodule

bind source_token_lexer stl_checker u_stl_checker (.*);

/* bench/tb_top.sv */
// Self-checking testbench for the byte-serial source token lexer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Token kinds, numbered in the order the lexer defines them.
    typedef enum logic [5:0] {
        TK_ID, TK_NUM,
        TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_LBRACK, TK_RBRACK,
        TK_COMMA, TK_DOT, TK_COLON, TK_SEMI, TK_QUEST, TK_UNDER,
        TK_EQ_EQ, TK_ASSIGN, TK_MUL_EQ, TK_MUL, TK_DIV_EQ, TK_DIV,
        TK_MOD_EQ, TK_MOD, TK_NOT_EQ, TK_NOT, TK_XOR_EQ, TK_XOR,
        TK_LOG_AND, TK_AND_EQ, TK_AND, TK_LOG_OR, TK_OR_EQ, TK_OR,
        TK_SUB_EQ, TK_DEC, TK_SUB, TK_ADD_EQ, TK_INC, TK_ADD,
        TK_LESS_EQ, TK_SHL_EQ, TK_SHL, TK_LESS,
        TK_GREATER_EQ, TK_SHR_EQ, TK_SHR, TK_GREATER,
        TK_END, TK_ERR
    } tok_kind_e;

    // Where the lexer stands between two bytes.
    typedef enum logic [2:0] {
        LX_IDLE, LX_OP1, LX_OP2, LX_COMMENT, LX_STRING, LX_WORD, LX_DONE, LX_ERROR
    } lex_mode_e;

    // One token record as it leaves the block.
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start_pos;
        logic [15:0] length;
        logic [19:0] line_no;
        logic [15:0] column_no;
        logic [31:0] token_index;
        logic        last;
    } token_rec_t;

    // Kinds an operator lead byte can grow into: alone, followed by '=',
    // doubled, and doubled then followed by '='.
    typedef struct packed {
        logic      lead;
        tok_kind_e alone;
        tok_kind_e with_eq;
        logic      doubles;
        tok_kind_e doubled;
        logic      triples;
        tok_kind_e tripled;
    } op_kinds_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Every operator spelling, one per operator kind.
    string op_texts [0:31] = '{
        "==", "=", "*=", "*", "/=", "/", "%=", "%", "!=", "!", "^=", "^",
        "&&", "&=", "&", "||", "|=", "|", "-=", "--", "-", "+=", "++", "+",
        "<=", "<<=", "<<", "<", ">=", ">>=", ">>", ">"
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_kind;
    logic [31:0] o_start_pos;
    logic [15:0] o_length;
    logic [19:0] o_line_no;
    logic [15:0] o_column_no;
    logic [31:0] o_token_index;
    logic        o_last;

    source_token_lexer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_start_pos   (o_start_pos),
        .o_length      (o_length),
        .o_line_no     (o_line_no),
        .o_column_no   (o_column_no),
        .o_token_index (o_token_index),
        .o_last        (o_last)
    );

    always #2 i_clk = ~i_clk;

    // Longest idle stretch each side may draw before its next transfer.
    int max_in_gap;
    int max_out_gap;

    int errors;
    int tokens_checked;
    int bytes_accepted;

    // Tokens the lexer owes us, oldest first.
    token_rec_t expected_tokens [$];

    // Mirror of the lexer state, advanced once per accepted byte.
    lex_mode_e   lx_mode;
    logic [7:0]  op_lead;
    logic        in_single_quote;
    logic        word_numeric;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [19:0] tok_line;
    logic [15:0] tok_col;
    logic [31:0] byte_pos;
    logic [19:0] line_cnt;
    logic [15:0] col_cnt;
    logic [31:0] tok_count;

    // Tokens produced by the byte being lexed; a byte makes at most two.
    token_rec_t step_out [2];
    int         step_n;

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // Bytes that close a word; they are then lexed on their own.
    function automatic logic is_word_end(input logic [7:0] c);
        return c == CH_NUL || is_blank(c) || c == "(" || c == ";" || c == ":" || c == "{";
    endfunction

    // Kind of a one-byte punctuation token; TK_ID means the byte is none.
    function automatic tok_kind_e punct_kind(input logic [7:0] c);
        case (c)
            "(":     return TK_LPAREN;
            ")":     return TK_RPAREN;
            "{":     return TK_LBRACE;
            "}":     return TK_RBRACE;
            "[":     return TK_LBRACK;
            "]":     return TK_RBRACK;
            ",":     return TK_COMMA;
            ".":     return TK_DOT;
            ":":     return TK_COLON;
            ";":     return TK_SEMI;
            "?":     return TK_QUEST;
            "_":     return TK_UNDER;
            default: return TK_ID;
        endcase
    endfunction

    function automatic op_kinds_t op_kinds(input logic [7:0] c);
        op_kinds_t o;
        o = '0;
        o.lead = 1'b1;
        case (c)
            "=": begin o.alone = TK_ASSIGN; o.with_eq = TK_EQ_EQ;  end
            "*": begin o.alone = TK_MUL;    o.with_eq = TK_MUL_EQ; end
            "/": begin o.alone = TK_DIV;    o.with_eq = TK_DIV_EQ; end
            "%": begin o.alone = TK_MOD;    o.with_eq = TK_MOD_EQ; end
            "!": begin o.alone = TK_NOT;    o.with_eq = TK_NOT_EQ; end
            "^": begin o.alone = TK_XOR;    o.with_eq = TK_XOR_EQ; end
            "&": begin
                o.alone = TK_AND; o.with_eq = TK_AND_EQ;
                o.doubles = 1'b1; o.doubled = TK_LOG_AND;
            end
            "|": begin
                o.alone = TK_OR; o.with_eq = TK_OR_EQ;
                o.doubles = 1'b1; o.doubled = TK_LOG_OR;
            end
            "-": begin
                o.alone = TK_SUB; o.with_eq = TK_SUB_EQ;
                o.doubles = 1'b1; o.doubled = TK_DEC;
            end
            "+": begin
                o.alone = TK_ADD; o.with_eq = TK_ADD_EQ;
                o.doubles = 1'b1; o.doubled = TK_INC;
            end
            "<": begin
                o.alone = TK_LESS; o.with_eq = TK_LESS_EQ;
                o.doubles = 1'b1; o.doubled = TK_SHL;
                o.triples = 1'b1; o.tripled = TK_SHL_EQ;
            end
            ">": begin
                o.alone = TK_GREATER; o.with_eq = TK_GREATER_EQ;
                o.doubles = 1'b1; o.doubled = TK_SHR;
                o.triples = 1'b1; o.tripled = TK_SHR_EQ;
            end
            default: o = '0;
        endcase
        return o;
    endfunction

    // True for every nonzero byte that the idle lexer takes without an error.
    function automatic logic starts_cleanly(input logic [7:0] c);
        op_kinds_t o;
        o = op_kinds(c);
        return is_blank(c) || c == "\"" || c == "'" || is_alnum(c) ||
               punct_kind(c) != TK_ID || o.lead;
    endfunction

    // ------------------------------------------------------------------
    // Lexer prediction
    // ------------------------------------------------------------------

    function automatic void lexer_reset();
        lx_mode         = LX_IDLE;
        op_lead         = '0;
        in_single_quote = 1'b0;
        word_numeric    = 1'b0;
        tok_start       = '0;
        tok_len         = '0;
        tok_line        = '0;
        tok_col         = '0;
        byte_pos        = '0;
        line_cnt        = '0;
        col_cnt         = '0;
        tok_count       = '0;
    endfunction

    function automatic void emit(input tok_kind_e kind, input logic [31:0] start,
                                 input logic [15:0] len, input logic [19:0] line,
                                 input logic [15:0] col, input logic [31:0] idx);
        if (step_n < 2) begin
            step_out[step_n] = '{kind, start, len, line, col, idx, 1'b0};
            step_n++;
        end
    endfunction

    // Sends the token that has been collected and returns to idle.
    function automatic void emit_collected(input tok_kind_e kind);
        emit(kind, tok_start, tok_len, tok_line, tok_col, tok_count);
        tok_count++;
        lx_mode = LX_IDLE;
    endfunction

    function automatic void open_token(input logic [15:0] len);
        tok_start = byte_pos;
        tok_line  = line_cnt;
        tok_col   = col_cnt;
        tok_len   = len;
    endfunction

    // A byte seen with no token under way.
    function automatic void lex_fresh(input logic [7:0] c);
        op_kinds_t o;
        tok_kind_e p;
        o = op_kinds(c);
        p = punct_kind(c);
        if (c == CH_NUL) begin
            emit(TK_END, byte_pos, 16'd0, line_cnt, col_cnt, tok_count);
            lx_mode = LX_DONE;
        end else if (is_blank(c)) begin
            // Separators make no token.
        end else if (c == "\"" || c == "'") begin
            // The string token starts at its first content byte.
            in_single_quote = (c == "'");
            tok_start = byte_pos + 32'd1;
            tok_line  = line_cnt;
            tok_col   = sat_inc(col_cnt);
            tok_len   = 16'd0;
            lx_mode   = LX_STRING;
        end else if (is_alnum(c)) begin
            word_numeric = (c <= "9");
            open_token(16'd1);
            lx_mode = LX_WORD;
        end else if (p != TK_ID) begin
            emit(p, byte_pos, 16'd1, line_cnt, col_cnt, tok_count);
            tok_count++;
        end else if (o.lead) begin
            op_lead = c;
            open_token(16'd1);
            lx_mode = LX_OP1;
        end else begin
            emit(TK_ERR, byte_pos, 16'd1, line_cnt, col_cnt, tok_count);
            lx_mode = LX_ERROR;
        end
    endfunction

    // Advances the mirror by one accepted byte and queues the tokens it owes.
    function automatic void lex_next_byte(input logic [7:0] c);
        op_kinds_t o;
        step_n = 0;
        if (lx_mode == LX_DONE || lx_mode == LX_ERROR)
            return;
        o = op_kinds(op_lead);
        case (lx_mode)
            LX_OP1: begin
                if (op_lead == "/" && c == "/") begin
                    lx_mode = LX_COMMENT;
                end else if (c == "=") begin
                    tok_len = 16'd2;
                    emit_collected(o.with_eq);
                end else if (o.doubles && c == op_lead) begin
                    if (o.triples) begin
                        lx_mode = LX_OP2;
                    end else begin
                        tok_len = 16'd2;
                        emit_collected(o.doubled);
                    end
                end else begin
                    // The operator is cut short and the byte starts over.
                    tok_len = 16'd1;
                    emit_collected(o.alone);
                    lex_fresh(c);
                end
            end
            LX_OP2: begin
                if (c == "=") begin
                    tok_len = 16'd3;
                    emit_collected(o.tripled);
                end else begin
                    tok_len = 16'd2;
                    emit_collected(o.doubled);
                    lex_fresh(c);
                end
            end
            LX_COMMENT: begin
                if (c == CH_LF)
                    lx_mode = LX_IDLE;
                else if (c == CH_NUL)
                    lex_fresh(c);
            end
            LX_STRING: begin
                if (c == (in_single_quote ? 8'("'") : 8'("\""))) begin
                    emit_collected(TK_ID);
                end else if (c == CH_NUL) begin
                    // Unterminated string: the error carries the string's place.
                    emit(TK_ERR, tok_start, tok_len, tok_line, tok_col, tok_count);
                    lx_mode = LX_ERROR;
                end else begin
                    tok_len = sat_inc(tok_len);
                end
            end
            LX_WORD: begin
                if (is_word_end(c)) begin
                    emit_collected(word_numeric ? TK_NUM : TK_ID);
                    lex_fresh(c);
                end else begin
                    tok_len = sat_inc(tok_len);
                end
            end
            default: lex_fresh(c);
        endcase

        if (c == CH_LF) begin
            line_cnt = line_cnt + 20'd1;
            col_cnt  = '0;
        end else begin
            col_cnt = sat_inc(col_cnt);
        end
        byte_pos++;

        for (int i = 0; i < step_n; i++) begin
            if (i == step_n - 1)
                step_out[i].last = 1'b1;
            expected_tokens.push_back(step_out[i]);
        end
    endfunction

    // True when the byte would end the stream, by an error or an end token.
    function automatic logic would_stop(input logic [7:0] c);
        if (c == CH_NUL)
            return 1'b1;
        return (lx_mode == LX_IDLE || lx_mode == LX_OP1 || lx_mode == LX_OP2) &&
               !starts_cleanly(c);
    endfunction

    function automatic logic [7:0] pick_bad_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (starts_cleanly(c));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one byte after a random idle stretch and waits for its transfer.
    // Called and returning at a falling edge.
    task automatic send_byte(input logic [7:0] c);
        int idle;
        idle = $urandom_range(0, max_in_gap);
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        do @(posedge i_clk); while (o_stall);
        lex_next_byte(c);
        bytes_accepted++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Sends the byte unless it would end the stream early; then a letter goes instead.
    task automatic send_safe(input logic [7:0] c);
        if (would_stop(c))
            c = 8'h61 + 8'($urandom_range(0, 25));
        send_byte(c);
    endtask

    // Brings the lexer back to idle so that a clean sequence can follow.
    task automatic close_open_token();
        while (lx_mode != LX_IDLE) begin
            case (lx_mode)
                LX_STRING:  send_byte(in_single_quote ? 8'("'") : 8'("\""));
                LX_COMMENT: send_byte(CH_LF);
                default:    send_byte(CH_SPACE);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Output side and checking
    // ------------------------------------------------------------------

    task automatic report(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("token %0d %s: got 0x%0h, expected 0x%0h",
                             tokens_checked, name, got, want));
    endtask

    // The receiver draws a stall stretch for each token, then takes one transfer.
    initial begin : output_side
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = $urandom_range(0, max_out_gap);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Every token transfer is compared with the oldest token still owed.
    always @(posedge i_clk) begin : token_check
        token_rec_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_tokens.size() == 0) begin
                report($sformatf("token with nothing owed: kind %0d at offset %0d",
                                 o_kind, o_start_pos));
            end else begin
                want = expected_tokens.pop_front();
                check_field("kind",        32'(o_kind),      32'(want.kind));
                check_field("start_pos",   o_start_pos,      want.start_pos);
                check_field("length",      32'(o_length),    32'(want.length));
                check_field("line_no",     32'(o_line_no),   32'(want.line_no));
                check_field("column_no",   32'(o_column_no), 32'(want.column_no));
                check_field("token_index", o_token_index,    want.token_index);
                check_field("last",        32'(o_last),      32'(want.last));
            end
            tokens_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identifiers and numbers, every byte but zero that ends a word, and words that
    // run over punctuation, operators and bytes above 127.
    task automatic test_words();
        send_text("x9 42z;Ab{7:q(w\tv\n0 Z1\na.b+c k");
        send_byte(8'hC3);
        send_byte(8'h0D);
        send_text("\n");
    endtask

    task automatic test_punctuation();
        send_text("(){}[],.:;?_\n");
    endtask

    // Every operator spelling on its own, so each operator kind comes out once.
    task automatic test_operator_kinds();
        foreach (op_texts[i]) begin
            send_text(op_texts[i]);
            send_byte(CH_SPACE);
        end
        send_byte(CH_LF);
    endtask

    // Operators that the next byte does not extend: the short operator goes
    // out and the byte is lexed afresh, sometimes as a token of its own.
    task automatic test_cut_short();
        send_text("+( <<x >>> !! -+ &&& |=| a<b <<{ =\"s\" %\n");
    endtask

    // Comments run to the newline, carry any byte, and leave a lone slash alone.
    task automatic test_comments();
        send_text("a //c");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_text(" x\n/x //\n/ /=\n");
    endtask

    // Both quote styles, empty strings, the other quote inside, and a
    // newline that is counted inside the string.
    task automatic test_strings();
        send_text("\"ab\ncd\" 'x\"y' '' \"\" \"");
        send_byte(8'hFE);
        send_byte(8'h0D);
        send_text("'\"\n");
    endtask

    // One long word of arbitrary bytes sent back to back, then a token after it.
    task automatic test_long_word();
        logic [7:0] c;
        max_in_gap  = 0;
        max_out_gap = 0;
        send_text("W");
        repeat (200) begin
            c = 8'($urandom_range(1, 255));
            if (is_word_end(c))
                c = "w";
            send_byte(c);
        end
        send_text(" z\n");
    endtask

    // One token's worth of bytes; most are well formed, some are noise.
    task automatic send_random_token();
        int pick;
        int n;
        logic [7:0] c;
        logic [7:0] closer;
        string puncts;
        puncts = "(){}[],.:;?_";
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_safe(($urandom_range(0, 2) == 0) ? 8'h30 + 8'($urandom_range(0, 9))
                                                  : 8'h41 + 8'($urandom_range(0, 25)));
            n = $urandom_range(0, 7);
            repeat (n) begin
                c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                : 8'h61 + 8'($urandom_range(0, 25));
                send_safe(c);
            end
            case ($urandom_range(0, 7))
                0: send_safe(CH_SPACE);
                1: send_safe(CH_LF);
                2: send_safe(CH_TAB);
                3: send_safe("(");
                4: send_safe(";");
                5: send_safe(":");
                6: send_safe("{");
                default: ;
            endcase
        end else if (pick < 45) begin
            send_text(op_texts[$urandom_range(0, 31)]);
            if ($urandom_range(0, 1) == 0)
                send_safe(CH_SPACE);
        end else if (pick < 55) begin
            send_safe(puncts[$urandom_range(0, 11)]);
        end else if (pick < 67) begin
            closer = ($urandom_range(0, 1) == 0) ? 8'("'") : 8'("\"");
            send_safe(closer);
            n = $urandom_range(0, 6);
            repeat (n) begin
                do c = 8'($urandom_range(1, 255)); while (c == closer);
                send_safe(c);
            end
            send_safe(closer);
        end else if (pick < 75) begin
            send_text("//");
            n = $urandom_range(0, 6);
            repeat (n) begin
                do c = 8'($urandom_range(1, 255)); while (c == CH_LF);
                send_safe(c);
            end
            send_safe(CH_LF);
        end else if (pick < 90) begin
            case ($urandom_range(0, 2))
                0:       send_safe(CH_SPACE);
                1:       send_safe(CH_TAB);
                default: send_safe(CH_LF);
            endcase
        end else begin
            send_safe(8'($urandom_range(1, 255)));
        end
    endtask

    // Random token streams in four stretches, each with its own idling on
    // the two sides, one of them with no idling at all.
    task automatic test_random_stream();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin max_in_gap = 5; max_out_gap = 5; end
                1: begin max_in_gap = 0; max_out_gap = 0; end
                2: begin max_in_gap = 0; max_out_gap = 5; end
                default: begin max_in_gap = 5; max_out_gap = 0; end
            endcase
            target = bytes_accepted + 300;
            while (bytes_accepted < target)
                send_random_token();
        end
        close_open_token();
    endtask

    // The stream can end only once per run, so one of the ways to end it is
    // drawn: end token alone or after a word or an operator, a bad byte alone
    // or after an operator, an unterminated string, or a comment that runs to
    // the end. Bytes after that, zero and bad ones among them, are dropped.
    task automatic test_end_of_input();
        max_in_gap  = 3;
        max_out_gap = 3;
        case ($urandom_range(0, 6))
            0: begin send_text(" end"); send_byte(CH_NUL); end
            1: begin send_text(" +");   send_byte(CH_NUL); end
            2: begin send_text(" \n");  send_byte(CH_NUL); end
            3: begin send_text(" <<");  send_byte(pick_bad_byte()); end
            4: begin send_text(" ");    send_byte(pick_bad_byte()); end
            5: begin send_text(" \"open\n"); send_byte(CH_NUL); end
            default: begin send_text(" // tail"); send_byte(CH_NUL); end
        endcase
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_NUL);
        send_byte(pick_bad_byte());
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ch           = '0;
        max_in_gap     = 3;
        max_out_gap    = 3;
        errors         = 0;
        tokens_checked = 0;
        bytes_accepted = 0;
        lexer_reset();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_words();
        test_punctuation();
        test_operator_kinds();
        test_cut_short();
        test_comments();
        test_strings();
        test_long_word();
        test_random_stream();
        test_end_of_input();

        // All bytes are in; let the owed tokens drain, then keep watching so
        // that a stray token can still show up.
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // A run that has not finished by this time is reported as failing.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
